// ===== hdl/edst_pkg.sv =====
`timescale 1ns / 1ps
package edst_pkg;

  localparam int OP_W   = 3;
  localparam int SLOT_W = 10;
  localparam int DL_W   = 40;
  localparam int SKIP_W = 24;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_SKIP   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  localparam logic [DL_W-1:0] DAY_SECONDS = 40'd86400;

  typedef struct packed {
    logic              used;
    logic [DL_W-1:0]   dl;
    logic [SKIP_W-1:0] skip;
  } slot_ent_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_DIV, S_RD0, S_RD1, S_RD2, S_RD3, S_RESP
  } state_t;

endpackage

// ===== hdl/edst_ram.sv =====
`timescale 1ns / 1ps
module edst_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/edst_div.sv =====
`timescale 1ns / 1ps
module edst_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [edst_pkg::DL_W-1:0] din,
  output logic                      done,
  output logic [edst_pkg::SKIP_W-1:0] quo
);
  import edst_pkg::*;

  // d / 86400 is (d >> 7) / 675; for a 33-bit operand n the quotient
  // n / 675 equals (n * RECIP) >> 43 with RECIP = ceil(2^43 / 675),
  // whose error term stays below 1/675 over the whole operand range
  localparam int NW = DL_W - 7;
  localparam int MW = 17;
  localparam int PW = NW + MW;
  localparam int AW = PW + MW;
  localparam int QS = 43;
  localparam logic [MW-1:0] RECIP_LO = 17'd70682;
  localparam logic [MW-1:0] RECIP_HI = 17'd99420;

  logic [NW-1:0] n_r;
  logic [AW-1:0] acc_r;
  logic          step_r;
  logic          busy_r;
  logic          done_r;
  logic [PW-1:0] pp;

  // multiply the operand by one half of the reciprocal
  always_comb begin
    pp = PW'(n_r) * PW'(step_r ? RECIP_HI : RECIP_LO);
  end

  // low half first, then add the shifted high half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 1'b0;
    end else begin
      done_r <= busy_r && step_r;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= 1'b0;
        n_r    <= din[DL_W-1:7];
      end else if (busy_r && !step_r) begin
        acc_r  <= AW'(pp);
        step_r <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_r + {pp, {MW{1'b0}}};
        busy_r <= 1'b0;
        step_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quo  = acc_r[QS +: SKIP_W];

endmodule

// ===== hdl/earliest_deadline_slot_table.sv =====
`timescale 1ns / 1ps
// Sequence: query, read and failed requests pass from execute straight to the
// result; insert, remove, update and skip then walk the tree to the root in
// states S_RD0..S_RD3 at each level (up to log2 SLOTS levels), and a skip that sets
// a skip day first waits in S_DIV for the divider. One request at a time: the next
// is taken once the result is loaded into the output register, after the walk.
// Reset: after rst_n the block sweeps all SLOTS entries, one per cycle, and
// accepts no request during the sweep.
module earliest_deadline_slot_table #(
  parameter int SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [edst_pkg::OP_W-1:0]   in_operation,
  input  logic [edst_pkg::SLOT_W-1:0] in_slot,
  input  logic [edst_pkg::DL_W-1:0]   in_deadline,
  input  logic [edst_pkg::SKIP_W-1:0] in_skip_day,
  input  logic [edst_pkg::DL_W-1:0]   in_now,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [edst_pkg::SLOT_W-1:0] out_result_slot,
  output logic [edst_pkg::DL_W-1:0]   out_result_deadline,
  output logic [edst_pkg::SKIP_W-1:0] out_result_skip_day,
  output logic                        out_table_empty
);
  import edst_pkg::*;

  localparam int SW = $clog2(SLOTS);

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DL_W-1:0]   dl_r, now_r, new_dl_r;
  logic [SKIP_W-1:0] sk_r;
  logic [SW-1:0]     fc_r, root_r, clr_r, node_r;
  logic              self_used_r;
  logic [DL_W-1:0]   self_dl_r, l_dl_r;
  logic [SW-1:0]     l_r, r_r;
  logic              res_ok_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [DL_W-1:0]   res_dl_r;
  logic [SKIP_W-1:0] res_sk_r;
  logic              out_valid_r, out_ok_r, out_empty_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [DL_W-1:0]   out_dl_r;
  logic [SKIP_W-1:0] out_sk_r;

  // memory ports
  logic            s_we, t_we, f_we;
  logic [SW-1:0]   s_waddr, t_waddr, f_waddr, s_raddr, t_raddr, f_raddr;
  slot_ent_t       s_wdata, s_rd;
  logic [SW-1:0]   t_wdata, t_rd, f_wdata, f_rd;

  logic            div_start, div_done;
  logic [SKIP_W-1:0] div_q;

  logic            in_rng, live, lex, rex;
  logic [SW-1:0]   b1, b2;
  logic [DL_W-1:0] b1_dl;

  edst_ram #(.W($bits(slot_ent_t)), .D(SLOTS)) u_smem (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rd)
  );

  edst_ram #(.W(SW), .D(SLOTS)) u_tmem (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rd)
  );

  edst_ram #(.W(SW), .D(SLOTS)) u_fmem (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rd)
  );

  edst_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .din(s_rd.dl),
    .done(div_done), .quo(div_q)
  );

  // decode slot liveness and child existence
  always_comb begin
    in_rng = (slot_r != '0) && (32'(slot_r) < SLOTS);
    live   = in_rng && s_rd.used;
    lex    = 32'({node_r, 1'b0}) < SLOTS;
    rex    = 32'({node_r, 1'b1}) < SLOTS;
  end

  // pick the earliest of node, left winner and right winner
  always_comb begin
    b1    = self_used_r ? node_r : '0;
    b1_dl = self_dl_r;
    if (l_r != '0 && (b1 == '0 || l_dl_r < b1_dl)) begin
      b1    = l_r;
      b1_dl = l_dl_r;
    end
    b2 = b1;
    if (r_r != '0 && (b1 == '0 || s_rd.dl < b1_dl)) begin
      b2 = r_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == SW'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        case (op_r)
          OP_INSERT: state_nxt = (fc_r != '0) ? S_RD0 : S_RESP;
          OP_REMOVE, OP_UPDATE: state_nxt = live ? S_RD0 : S_RESP;
          OP_SKIP: begin
            if (!live) state_nxt = S_RESP;
            else if (s_rd.skip != '0) state_nxt = S_RD0;
            else state_nxt = S_DIV;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_DIV:  if (div_done) state_nxt = S_RD0;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_RD3;
      S_RD3:  state_nxt = (node_r == SW'(1)) ? S_RESP : S_RD0;
      S_RESP: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  // memory controls
  always_comb begin
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    div_start = 1'b0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_CLR: begin
        s_we = 1'b1; s_waddr = clr_r;
        t_we = 1'b1; t_waddr = clr_r;
        f_we = 1'b1; f_waddr = clr_r; f_wdata = SW'(SLOTS - 1) - clr_r;
      end
      S_IDLE: begin
        s_raddr = (in_operation == OP_QUERY) ? root_r : SW'(in_slot);
        f_raddr = fc_r - SW'(1);
      end
      S_EXEC: begin
        case (op_r)
          OP_INSERT: begin
            s_we = (fc_r != '0); s_waddr = f_rd;
            s_wdata = '{used: 1'b1, dl: dl_r, skip: sk_r};
          end
          OP_REMOVE: begin
            s_we = live; s_waddr = SW'(slot_r);
            s_wdata = '{used: 1'b0, dl: s_rd.dl, skip: s_rd.skip};
            f_we = live && (fc_r != SW'(SLOTS - 1));
            f_waddr = fc_r; f_wdata = SW'(slot_r);
          end
          OP_UPDATE: begin
            s_we = live; s_waddr = SW'(slot_r);
            s_wdata = '{used: 1'b1, dl: dl_r, skip: sk_r};
          end
          OP_SKIP: begin
            s_we = live && (s_rd.skip != '0); s_waddr = SW'(slot_r);
            s_wdata = '{used: 1'b1, dl: s_rd.dl - DAY_SECONDS, skip: '0};
            div_start = live && (s_rd.skip == '0);
          end
          default: ;
        endcase
      end
      S_DIV: begin
        s_we = div_done; s_waddr = SW'(slot_r);
        s_wdata = '{used: 1'b1, dl: new_dl_r + DAY_SECONDS, skip: div_q};
      end
      S_RD0: begin
        s_raddr = node_r;
        t_raddr = {node_r[SW-2:0], 1'b0};
      end
      S_RD1: begin
        s_raddr = t_rd;
        t_raddr = {node_r[SW-2:0], 1'b1};
      end
      S_RD2: s_raddr = t_rd;
      S_RD3: begin
        t_we = 1'b1; t_waddr = node_r; t_wdata = b2;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      fc_r        <= SW'(SLOTS - 1);
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + SW'(1);
      if (state_r == S_EXEC && op_r == OP_INSERT && fc_r != '0) fc_r <= fc_r - SW'(1);
      if (state_r == S_EXEC && op_r == OP_REMOVE && live && fc_r != SW'(SLOTS - 1)) begin
        fc_r <= fc_r + SW'(1);
      end
      if (state_r == S_RD3 && node_r == SW'(1)) root_r <= b2;
      if (state_r == S_RESP && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // request, result and tree walk datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r <= in_operation; slot_r <= in_slot; dl_r <= in_deadline;
      sk_r <= in_skip_day;  now_r <= in_now;
    end
    if (state_r == S_EXEC) begin
      res_ok_r <= 1'b0; res_slot_r <= '0; res_dl_r <= '0; res_sk_r <= '0;
      new_dl_r <= s_rd.dl;
      node_r   <= (op_r == OP_INSERT) ? f_rd : SW'(slot_r);
      case (op_r)
        OP_INSERT: begin
          if (fc_r != '0) begin
            res_ok_r <= 1'b1; res_slot_r <= SLOT_W'(f_rd);
            res_dl_r <= dl_r; res_sk_r <= sk_r;
          end
        end
        OP_REMOVE: res_ok_r <= live;
        OP_UPDATE: if (live) begin
          res_ok_r <= 1'b1; res_dl_r <= dl_r; res_sk_r <= sk_r;
        end
        OP_SKIP: if (live) begin
          res_ok_r <= 1'b1;
          res_dl_r <= s_rd.dl - DAY_SECONDS;
        end
        OP_QUERY: if (root_r != '0 && s_rd.dl <= now_r) begin
          res_ok_r <= 1'b1; res_slot_r <= SLOT_W'(root_r);
          res_dl_r <= s_rd.dl; res_sk_r <= s_rd.skip;
        end
        OP_READ: if (live) begin
          res_ok_r <= 1'b1; res_dl_r <= s_rd.dl; res_sk_r <= s_rd.skip;
        end
        default: ;
      endcase
    end
    if (state_r == S_DIV && div_done) begin
      res_dl_r <= new_dl_r + DAY_SECONDS;
      res_sk_r <= div_q;
    end
    if (state_r == S_RD1) begin
      self_used_r <= s_rd.used; self_dl_r <= s_rd.dl;
      l_r <= lex ? t_rd : '0;
    end
    if (state_r == S_RD2) begin
      r_r <= rex ? t_rd : '0;
      l_dl_r <= s_rd.dl;
    end
    if (state_r == S_RD3) node_r <= node_r >> 1;
    if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
      out_ok_r <= res_ok_r; out_slot_r <= res_slot_r;
      out_dl_r <= res_dl_r; out_sk_r <= res_sk_r;
      out_empty_r <= (root_r == '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_result_slot     = out_slot_r;
  assign out_result_deadline = out_dl_r;
  assign out_result_skip_day = out_sk_r;
  assign out_table_empty     = out_empty_r;

endmodule

// ===== hdl/edst_checker.sv =====
`timescale 1ns / 1ps
module edst_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_ok,
  input logic [edst_pkg::SLOT_W-1:0] out_result_slot,
  input logic [edst_pkg::DL_W-1:0]   out_result_deadline,
  input logic [edst_pkg::SKIP_W-1:0] out_result_skip_day,
  input logic                        out_table_empty
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // drop all data on a failed request
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_result_slot == '0 && out_result_deadline == '0
      && out_result_skip_day == '0)
    else $error("failed request carries data");

  // a returned slot implies an occupied table
  a_slot_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_slot != '0 |-> out_ok && !out_table_empty)
    else $error("slot returned from empty table");

  // take one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken during work");

endmodule

bind earliest_deadline_slot_table edst_checker u_edst_checker (.*);
